// ===== src/utf8d_pkg.sv =====
// Shared types, constants and byte classification functions of the UTF-8 decoder.
package utf8d_pkg;

	localparam int OFFSET_WIDTH_DEF = 32;
	localparam int FIFO_DEPTH       = 4;
	localparam int CP_WIDTH         = 21;

	localparam logic [7:0] LEAD4_MIN    = 8'hF0;
	localparam logic [7:0] LEAD3_MIN    = 8'hE0;
	localparam logic [7:0] LEAD2_MIN    = 8'hC0;
	localparam logic [7:0] BITS4_MASK   = 8'h07;
	localparam logic [7:0] BITS3_MASK   = 8'h0F;
	localparam logic [7:0] BITS2_MASK   = 8'h1F;
	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_TAG     = 8'h80;
	localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	typedef struct packed {
		logic                     full_seq;
		logic [2:0]               n_cp;
		logic                     end_mark;
		logic [CP_WIDTH-1:0]      cp;
		logic [3:0][7:0]          bytes;
	} job_info_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		priority if (b >= LEAD4_MIN) begin
			len = LEN_FOUR;
		end else if (b >= LEAD3_MIN) begin
			len = LEN_THREE;
		end else if (b >= LEAD2_MIN) begin
			len = LEN_TWO;
		end else begin
			len = LEN_ONE;
		end
		return len;
	endfunction

	function automatic logic [CP_WIDTH-1:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
		logic [CP_WIDTH-1:0] bits;
		unique case (len)
			LEN_FOUR:  bits = CP_WIDTH'(b & BITS4_MASK);
			LEN_THREE: bits = CP_WIDTH'(b & BITS3_MASK);
			LEN_TWO:   bits = CP_WIDTH'(b & BITS2_MASK);
			default:   bits = CP_WIDTH'(b);
		endcase
		return bits;
	endfunction

endpackage

// ===== src/utf8_decoder_latin1_fallback_top.sv =====
// Top level of the streaming UTF-8 decoder with Latin-1 fallback.
//
// Input side is a queue: a byte word is taken at a clock edge with push high and
// full low. final_byte marks the last byte of a text; after it one end marker
// word carries the total length and the next byte starts a new text at offset 0.
// Result side is a queue too: while empty is low the oldest word is on the
// result ports, and it leaves at an edge with pop high.
// Each byte gives zero to five result words; last_of_run flags the last word
// caused by one byte. A word passes through the job queue, the job register and the output register.
// Bytes are taken one per cycle while full is low; results leave one per cycle
// from the back end while pop is high, so one byte per cycle is sustained while
// bytes yield at most one word each. A four-entry job queue between front and back
// absorbs fallback bursts; when it fills, full rises until the back end drains a job.
// When pop stays low, the output register holds its word, the job queue fills
// and full then stalls the input; nothing is lost.
// Reset clears the open sequence, the byte count and both queues.
module utf8_decoder_latin1_fallback_top import utf8d_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                final_byte,
	input  logic                push,
	output logic                full,
	output logic [CP_WIDTH-1:0] code_point,
	output logic [31:0]         start_offset,
	output logic                end_marker,
	output logic                last_of_run,
	output logic                empty,
	input  logic                pop
);

	localparam int JOB_W = $bits(job_info_t) + 2 * OFFSET_WIDTH;

	logic                    accept;
	logic                    job_push;
	job_info_t               job_info, q_info;
	logic [OFFSET_WIDTH-1:0] job_base, job_end, q_base, q_end;
	logic [JOB_W-1:0]        q_rd_data;
	logic                    q_full, q_empty, q_pop;

	assign accept = push && !q_full;
	assign full   = q_full;

	utf8d_front #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.accept    (accept),
		.job_push  (job_push),
		.job_info  (job_info),
		.job_base  (job_base),
		.job_end   (job_end)
	);

	utf8d_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data({job_info, job_base, job_end}),
		.rd_en  (q_pop),
		.rd_data(q_rd_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {q_info, q_base, q_end} = q_rd_data;

	utf8d_back #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (q_empty),
		.fifo_info   (q_info),
		.fifo_base   (q_base),
		.fifo_end    (q_end),
		.fifo_pop    (q_pop),
		.pop         (pop),
		.empty       (empty),
		.code_point  (code_point),
		.start_offset(start_offset),
		.end_marker  (end_marker),
		.last_of_run (last_of_run)
	);

endmodule

// ===== src/utf8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence and builds a job for each byte that yields words or ends a text.
module utf8d_front import utf8d_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              data_byte,
	input  logic                    final_byte,
	input  logic                    accept,
	output logic                    job_push,
	output job_info_t               job_info,
	output logic [OFFSET_WIDTH-1:0] job_base,
	output logic [OFFSET_WIDTH-1:0] job_end
);

	logic [2:0][7:0]         pend_q, pend_nxt;
	logic [1:0]              pcount_q, pcount_nxt;
	logic [2:0]              seqlen_q, seqlen_nxt;
	logic [CP_WIDTH-1:0]     partial_q, partial_nxt;
	logic [OFFSET_WIDTH-1:0] count_q, cnt_new;

	logic [3:0][7:0]         w;
	logic [2:0]              bl;
	logic                    cont_ok;
	logic [CP_WIDTH-1:0]     new_part;

	assign cnt_new  = count_q + OFFSET_WIDTH'(1);
	assign job_end  = cnt_new;
	assign job_base = cnt_new - (OFFSET_WIDTH'(pcount_q) + OFFSET_WIDTH'(1));
	assign bl       = lead_length(data_byte);
	assign cont_ok  = (data_byte & CONT_MASK) == CONT_TAG;
	assign new_part = {partial_q[CP_WIDTH-7:0], 6'(data_byte & PAYLOAD_MASK)};

	always_comb begin
		w[0] = pend_q[0];
		w[1] = pend_q[1];
		w[2] = pend_q[2];
		w[3] = 8'h00;
		w[pcount_q] = data_byte;
	end

	always_comb begin
		job_info          = '0;
		job_info.bytes    = w;
		job_info.end_mark = final_byte;
		pend_nxt          = pend_q;
		pcount_nxt        = 2'd0;
		seqlen_nxt        = LEN_ONE;
		partial_nxt       = '0;
		if (pcount_q == 2'd0) begin
			if ((bl == LEN_ONE) || final_byte) begin
				job_info.n_cp = 3'd1;
			end else begin
				pend_nxt[0] = data_byte;
				pcount_nxt  = 2'd1;
				seqlen_nxt  = bl;
				partial_nxt = lead_bits(data_byte, bl);
			end
		end else if (cont_ok) begin
			if (({1'b0, pcount_q} + 3'd1) == seqlen_q) begin
				job_info.full_seq = 1'b1;
				job_info.cp       = new_part;
				job_info.n_cp     = 3'd1;
			end else if (final_byte) begin
				job_info.n_cp = {1'b0, pcount_q} + 3'd1;
			end else begin
				pend_nxt[pcount_q] = data_byte;
				pcount_nxt         = pcount_q + 2'd1;
				seqlen_nxt         = seqlen_q;
				partial_nxt        = new_part;
			end
		end else begin
			if ((bl == LEN_ONE) || final_byte) begin
				job_info.n_cp = {1'b0, pcount_q} + 3'd1;
			end else begin
				job_info.n_cp = {1'b0, pcount_q};
				pend_nxt[0]   = data_byte;
				pcount_nxt    = 2'd1;
				seqlen_nxt    = bl;
				partial_nxt   = lead_bits(data_byte, bl);
			end
		end
		if (final_byte) begin
			pend_nxt = '0;
		end
	end

	assign job_push = accept && ((job_info.n_cp != 3'd0) || final_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			pcount_q  <= 2'd0;
			seqlen_q  <= LEN_ONE;
			partial_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			pend_q    <= pend_nxt;
			pcount_q  <= pcount_nxt;
			seqlen_q  <= seqlen_nxt;
			partial_q <= partial_nxt;
			count_q   <= final_byte ? '0 : cnt_new;
		end
	end

endmodule

// ===== src/utf8d_fifo.sv =====
// Short job queue between the front end and the result sequencer.
module utf8d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/utf8d_back.sv =====
// Back end: expands each job into result words and holds the output register.
module utf8d_back import utf8d_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fifo_empty,
	input  job_info_t               fifo_info,
	input  logic [OFFSET_WIDTH-1:0] fifo_base,
	input  logic [OFFSET_WIDTH-1:0] fifo_end,
	output logic                    fifo_pop,
	input  logic                    pop,
	output logic                    empty,
	output logic [CP_WIDTH-1:0]     code_point,
	output logic [31:0]             start_offset,
	output logic                    end_marker,
	output logic                    last_of_run
);

	job_info_t               job_q;
	logic [OFFSET_WIDTH-1:0] base_q, end_q;
	logic                    job_valid_q;
	logic [2:0]              idx_q;

	logic                    out_valid_q;
	logic [CP_WIDTH-1:0]     code_point_q;
	logic [31:0]             start_offset_q;
	logic                    end_marker_q;
	logic                    last_of_run_q;

	logic [2:0]              total;
	logic                    advance, last, take;
	logic [CP_WIDTH-1:0]     res_cp;
	logic [OFFSET_WIDTH-1:0] res_off;
	logic                    res_end;

	assign total    = job_q.n_cp + 3'(job_q.end_mark);
	assign advance  = job_valid_q && (!out_valid_q || pop);
	assign last     = idx_q == (total - 3'd1);
	assign take     = !fifo_empty && (!job_valid_q || (advance && last));
	assign fifo_pop = take;

	always_comb begin
		if (idx_q < job_q.n_cp) begin
			res_cp  = job_q.full_seq ? job_q.cp : CP_WIDTH'(job_q.bytes[idx_q[1:0]]);
			res_off = base_q + OFFSET_WIDTH'(idx_q);
			res_end = 1'b0;
		end else begin
			res_cp  = '0;
			res_off = end_q;
			res_end = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q  <= fifo_info;
			base_q <= fifo_base;
			end_q  <= fifo_end;
		end
		if (advance) begin
			code_point_q   <= res_cp;
			start_offset_q <= 32'(res_off);
			end_marker_q   <= res_end;
			last_of_run_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				job_valid_q <= 1'b1;
				idx_q       <= 3'd0;
			end else if (advance) begin
				if (last) begin
					job_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty        = !out_valid_q;
	assign code_point   = code_point_q;
	assign start_offset = start_offset_q;
	assign end_marker   = end_marker_q;
	assign last_of_run  = last_of_run_q;

`ifndef ASSERT_OFF
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (idx_q < total))
		else $error("Result index ran past the end of the job.");

	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (total != 3'd0))
		else $error("A job without results reached the back end.");

	a_marker_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_marker_q) |-> (last_of_run_q && (code_point_q == '0)))
		else $error("End marker word is not the closing word of its run.");

	a_job_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last && fifo_empty) |=> !job_valid_q)
		else $error("Finished job stayed active.");
`endif

endmodule

// ===== sim/utf8_codepoint_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the decoder's code point words from accepted bytes and compares them.
module utf8_codepoint_checker import utf8d_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                final_byte,
	input  logic                push,
	input  logic                full,
	input  logic [CP_WIDTH-1:0] code_point,
	input  logic [31:0]         start_offset,
	input  logic                end_marker,
	input  logic                last_of_run,
	input  logic                empty,
	input  logic                pop,
	output int                  mismatches,
	output int                  words_pending,
	output int                  words_checked
);

	typedef struct packed {
		logic [CP_WIDTH-1:0] cp;
		logic [31:0]         off;
		logic                marker;
		logic                closes_run;
	} cp_word_t;

	cp_word_t    expected_cps [$];
	cp_word_t    want;
	logic [7:0]  held_bytes [3];
	int          held_count;
	logic [31:0] text_len;

	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		logic [7:0]          seq [4];
		cp_word_t            run [$];
		cp_word_t            w;
		logic [CP_WIDTH-1:0] cp;
		logic [7:0]          b0;
		int                  n, i, k, len, avail, lim;
		bit                  broken;
		for (k = 0; k < held_count; k++) begin
			seq[k] = held_bytes[k];
		end
		seq[held_count] = b;
		n = held_count + 1;
		text_len = text_len + 32'd1;
		held_count = 0;
		i = 0;
		while (i < n) begin
			b0 = seq[i];
			avail = n - i;
			if (b0 >= LEAD4_MIN) begin
				len = 4;
				cp = CP_WIDTH'(b0 & BITS4_MASK);
			end else if (b0 >= LEAD3_MIN) begin
				len = 3;
				cp = CP_WIDTH'(b0 & BITS3_MASK);
			end else if (b0 >= LEAD2_MIN) begin
				len = 2;
				cp = CP_WIDTH'(b0 & BITS2_MASK);
			end else begin
				len = 1;
				cp = CP_WIDTH'(b0);
			end
			w.off = text_len - 32'(avail);
			w.marker = 1'b0;
			w.closes_run = 1'b0;
			lim = (len < avail) ? len : avail;
			broken = 1'b0;
			for (k = 1; k < lim && !broken; k++) begin
				if ((seq[i+k] & CONT_MASK) != CONT_TAG) begin
					broken = 1'b1;
				end else begin
					cp = (cp << 6) | CP_WIDTH'(seq[i+k] & PAYLOAD_MASK);
				end
			end
			if (len == 1 || broken || (avail < len && fin)) begin
				// The lead byte falls back to Latin-1 and the rest is read again as leads.
				w.cp = CP_WIDTH'(b0);
				run = {run, w};
				i++;
			end else if (avail >= len) begin
				w.cp = cp;
				run = {run, w};
				i += len;
			end else begin
				for (k = 0; k < avail; k++) begin
					held_bytes[k] = seq[i+k];
				end
				held_count = avail;
				i = n;
			end
		end
		if (fin) begin
			w.cp = '0;
			w.off = text_len;
			w.marker = 1'b1;
			w.closes_run = 1'b0;
			run = {run, w};
			text_len = '0;
			held_count = 0;
		end
		if (run.size() > 0) begin
			run[run.size()-1].closes_run = 1'b1;
		end
		expected_cps = {expected_cps, run};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_cps.delete();
			held_count = 0;
			text_len = '0;
			held_bytes[0] = '0;
			held_bytes[1] = '0;
			held_bytes[2] = '0;
			mismatches = 0;
			words_pending = 0;
			words_checked = 0;
		end else begin
			if (pop && !empty) begin
				words_checked++;
				if (expected_cps.size() == 0) begin
					$error("word with no expectation: code_point %0h, start_offset %0d",
						code_point, start_offset);
					mismatches++;
				end else begin
					want = expected_cps.pop_front();
					if (code_point !== want.cp) begin
						$error("code_point: expected %0h, got %0h", want.cp, code_point);
						mismatches++;
					end
					if (start_offset !== want.off) begin
						$error("start_offset: expected %0d, got %0d", want.off, start_offset);
						mismatches++;
					end
					if (end_marker !== want.marker) begin
						$error("end_marker: expected %0b, got %0b", want.marker, end_marker);
						mismatches++;
					end
					if (last_of_run !== want.closes_run) begin
						$error("last_of_run: expected %0b, got %0b", want.closes_run,
							last_of_run);
						mismatches++;
					end
				end
			end
			if (push && !full) begin
				decode_byte(data_byte, final_byte);
			end
			words_pending = expected_cps.size();
		end
	end

endmodule

// ===== sim/utf8_decoder_latin1_fallback_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top that feeds byte texts to the UTF-8 decoder and gives the verdict.
module utf8_decoder_latin1_fallback_top_test;
	import utf8d_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	logic                clk;
	logic                arst_n;
	logic [7:0]          data_byte;
	logic                final_byte;
	logic                push;
	logic                full;
	logic [CP_WIDTH-1:0] code_point;
	logic [31:0]         start_offset;
	logic                end_marker;
	logic                last_of_run;
	logic                empty;
	logic                pop;

	int mismatches;
	int words_pending;
	int words_checked;

	int         send_idle_pct;
	int         recv_stall_pct;
	bit         hold_armed;
	bit         hold_taken;
	int         hold_left;
	int         idle_cycles;
	int         bytes_sent;
	int         phase_bytes;
	int         texts_sent;
	int         texts_cut;
	logic [7:0] text_q [$];

	logic [7:0] directed_bytes [25] = '{
		8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
		8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'hBF, 8'hBF, 8'hBF,
		8'hC2, 8'h41, 8'hE0, 8'h80, 8'h41,
		8'hF4, 8'h8F, 8'hBF
	};

	utf8_decoder_latin1_fallback_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.final_byte   (final_byte),
		.push         (push),
		.full         (full),
		.code_point   (code_point),
		.start_offset (start_offset),
		.end_marker   (end_marker),
		.last_of_run  (last_of_run),
		.empty        (empty),
		.pop          (pop)
	);

	utf8_codepoint_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.final_byte    (final_byte),
		.push          (push),
		.full          (full),
		.code_point    (code_point),
		.start_offset  (start_offset),
		.end_marker    (end_marker),
		.last_of_run   (last_of_run),
		.empty         (empty),
		.pop           (pop),
		.mismatches    (mismatches),
		.words_pending (words_pending),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	function automatic logic [7:0] random_lead(input int len);
		logic [7:0] lead;
		if (len == 4) begin
			lead = 8'($urandom_range(8'hF0, 8'hFF));
		end else if (len == 3) begin
			lead = 8'($urandom_range(8'hE0, 8'hEF));
		end else begin
			lead = 8'($urandom_range(8'hC0, 8'hDF));
		end
		return lead;
	endfunction

	function automatic logic [7:0] random_cont();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	task automatic add_char();
		int pick, len;
		pick = $urandom_range(99);
		if (pick < 35) begin
			text_q = {text_q, 8'($urandom_range(0, 127))};
		end else if (pick < 85) begin
			len = (pick < 55) ? 2 : (pick < 70) ? 3 : 4;
			text_q = {text_q, random_lead(len)};
			repeat (len - 1) text_q = {text_q, random_cont()};
		end else if (pick < 92) begin
			text_q = {text_q, random_cont()};
		end else begin
			len = $urandom_range(2, 4);
			text_q = {text_q, random_lead(len)};
			repeat ($urandom_range(0, len - 2)) text_q = {text_q, random_cont()};
			if ($urandom_range(1)) begin
				text_q = {text_q, 8'($urandom_range(0, 127))};
			end else begin
				text_q = {text_q, 8'($urandom_range(8'hC0, 8'hFF))};
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do begin
			@(posedge clk);
		end while (full);
		bytes_sent++;
		phase_bytes++;
		if (fin) begin
			texts_sent++;
		end
		@(negedge clk);
	endtask

	task automatic send_text(input bit cut_short);
		int chars, j, len;
		text_q.delete();
		chars = $urandom_range(1, 16);
		repeat (chars) add_char();
		if (cut_short) begin
			len = $urandom_range(2, 4);
			text_q = {text_q, random_lead(len)};
			repeat ($urandom_range(0, len - 2)) text_q = {text_q, random_cont()};
			texts_cut++;
		end
		for (j = 0; j < text_q.size(); j++) begin
			send_byte(text_q[j], j == text_q.size() - 1);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do begin
			@(negedge clk);
		end while (words_pending != 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int nbytes);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		phase_bytes = 0;
		while (phase_bytes < nbytes) begin
			send_text($urandom_range(3) == 0);
		end
		wait_drained();
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	initial begin
		hold_taken = 1'b0;
		hold_left = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: %0d cycles with no word moving", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int j;
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		final_byte = 1'b0;
		hold_armed = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_cycles = 0;
		bytes_sent = 0;
		texts_sent = 0;
		texts_cut = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Extremes, every sequence length, stray and broken continuations, and a text
		// that ends inside a four-byte sequence.
		for (j = 0; j < 25; j++) begin
			send_byte(directed_bytes[j], j == 21 || j == 24);
		end
		wait_drained();

		hold_armed = 1'b1;
		run_phase(0, 0, 90);
		run_phase(68, 0, 90);
		run_phase(0, 68, 90);
		run_phase(23, 23, 90);

		repeat (8) @(negedge clk);
		$display("Sent %0d bytes in %0d texts, %0d of them ending inside a sequence;",
			bytes_sent, texts_sent, texts_cut);
		$display("checked %0d words under free flow, sender gaps, receiver stalls and a hold.",
			words_checked);
		if (mismatches == 0 && words_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
